// File: sv/xt256_pkg.sv
// ----------------------------------------------------------------------------
// xt256_pkg: shared types and helpers for the nearest palette match
// Holds the pipeline item type, palette constants and small channel helpers.
// ----------------------------------------------------------------------------
package xt256_pkg;

  localparam int CubeFirstIndex = 16;
  localparam int CubeRowStride  = 36;
  localparam int CubeColStride  = 6;
  localparam int GrayFirstIndex = 232;
  localparam int GrayCount      = 24;
  localparam int GrayBase       = 8;
  localparam int GrayStep       = 10;

  // Level codes of the color cube, one per channel
  typedef enum logic [2:0] {
    LVL_0   = 3'd0,
    LVL_95  = 3'd1,
    LVL_135 = 3'd2,
    LVL_175 = 3'd3,
    LVL_215 = 3'd4,
    LVL_255 = 3'd5
  } cube_lvl_t;

  // One item as it travels down the chain: the color and the best match so far
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] idx;
    logic [9:0] diff_sum;
  } xt_item_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Nearest cube level of one channel; on a tie the lower level wins
  function automatic cube_lvl_t cube_nearest(input logic [7:0] v);
    cube_lvl_t code;
    if (v <= 8'd47) begin
      code = LVL_0;
    end else if (v <= 8'd115) begin
      code = LVL_95;
    end else if (v <= 8'd155) begin
      code = LVL_135;
    end else if (v <= 8'd195) begin
      code = LVL_175;
    end else if (v <= 8'd235) begin
      code = LVL_215;
    end else begin
      code = LVL_255;
    end
    cube_nearest = code;
  endfunction

  function automatic logic [7:0] cube_level(input cube_lvl_t code);
    logic [7:0] lvl;
    case (code)
      LVL_0:   lvl = 8'd0;
      LVL_95:  lvl = 8'd95;
      LVL_135: lvl = 8'd135;
      LVL_175: lvl = 8'd175;
      LVL_215: lvl = 8'd215;
      LVL_255: lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    cube_level = lvl;
  endfunction

endpackage

// File: sv/xt256_cube.sv
// ----------------------------------------------------------------------------
// xt256_cube: head cell of the match chain
// Finds the nearest color cube entry; distance is separable per channel.
// ----------------------------------------------------------------------------
module xt256_cube (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               in_valid,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               valid,
  output xt256_pkg::xt_item_t item
);
  import xt256_pkg::*;

  cube_lvl_t r_code;
  cube_lvl_t g_code;
  cube_lvl_t b_code;
  xt_item_t  item_next;

  always_comb begin
    r_code = cube_nearest(red);
    g_code = cube_nearest(green);
    b_code = cube_nearest(blue);
    item_next.red   = red;
    item_next.green = green;
    item_next.blue  = blue;
    item_next.idx   = 8'(CubeFirstIndex)
                    + 8'(CubeRowStride) * {5'd0, r_code}
                    + 8'(CubeColStride) * {5'd0, g_code}
                    + {5'd0, b_code};
    item_next.diff_sum = 10'(abs_diff(red, cube_level(r_code)))
                       + 10'(abs_diff(green, cube_level(g_code)))
                       + 10'(abs_diff(blue, cube_level(b_code)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

// File: sv/xt256_gray_cell.sv
// ----------------------------------------------------------------------------
// xt256_gray_cell: one gray ramp entry of the match chain
// Compares the item with its gray level and keeps the nearer match.
// ----------------------------------------------------------------------------
module xt256_gray_cell #(
  parameter int Position = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               in_valid,
  input  xt256_pkg::xt_item_t in_item,
  output logic               valid,
  output xt256_pkg::xt_item_t item
);
  import xt256_pkg::*;

  localparam logic [7:0] Level = 8'(GrayBase + GrayStep * Position);
  localparam logic [7:0] Index = 8'(GrayFirstIndex + Position);

  logic [9:0] cand_sum;
  xt_item_t   item_next;

  always_comb begin
    cand_sum = 10'(abs_diff(in_item.red, Level))
             + 10'(abs_diff(in_item.green, Level))
             + 10'(abs_diff(in_item.blue, Level));
    item_next = in_item;
    // strict compare: an earlier (lower) index keeps a tie
    if (cand_sum < in_item.diff_sum) begin
      item_next.idx      = Index;
      item_next.diff_sum = cand_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

// File: sv/nearest_xterm256_color.sv
// ----------------------------------------------------------------------------
// nearest_xterm256_color: nearest 256-color terminal palette entry
// Matches a 24-bit color against palette entries 16..255 by Manhattan
// distance and returns the nearest index (lowest on ties) and its distance.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   in      | in_valid / in_ready | red[7:0] green[7:0] blue[7:0]
//   out     | out_valid/out_ready | palette_index[7:0] distance[9:0]
//
// Rate: one item per clock while out_ready holds; the chain has one cube cell
//   plus one cell for each of the 24 gray ramp entries.
// Reset: clears the valid bit of every cell; the payload registers are not reset.
// Stalls: each cell advances when it is empty or its successor advances, so
//   bubbles close up and input is taken while a result waits at the output
//   as long as some cell of the chain is empty.
// ----------------------------------------------------------------------------
module nearest_xterm256_color (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] palette_index,
  output logic [9:0] distance
);
  import xt256_pkg::*;

  localparam int Stages = GrayCount + 1;

  // Stage 0 is the cube cell, stages 1..GrayCount are the gray cells
  logic     valid [Stages];
  xt_item_t item  [Stages];
  logic     move  [Stages];

  // Advance a stage when it is empty or its successor advances
  generate
    for (genvar s = 0; s < Stages - 1; s++) begin : g_move
      assign move[s] = !valid[s] || move[s + 1];
    end
  endgenerate
  assign move[Stages - 1] = !valid[Stages - 1] || out_ready;

  assign in_ready = move[0];

  // Head cell: nearest cube entry
  xt256_cube u_cube (
    .clk      (clk),
    .rst      (rst),
    .load     (move[0]),
    .in_valid (in_valid),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .valid    (valid[0]),
    .item     (item[0])
  );

  // Gray ramp cells in ascending index order; hand the best match along
  generate
    for (genvar k = 0; k < GrayCount; k++) begin : g_gray
      xt256_gray_cell #(
        .Position (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (move[k + 1]),
        .in_valid (valid[k]),
        .in_item  (item[k]),
        .valid    (valid[k + 1]),
        .item     (item[k + 1])
      );
    end
  endgenerate

  // The last cell doubles as the output register
  assign out_valid     = valid[Stages - 1];
  assign palette_index = item[Stages - 1].idx;
  assign distance      = item[Stages - 1].diff_sum;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A result never points into the user-defined entries
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (palette_index >= 8'(CubeFirstIndex)))
    else $error("palette index below the cube");

  // A gray result carries the distance to its own ramp level
  a_gray_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (palette_index >= 8'(GrayFirstIndex))) |->
      (distance ==
        10'(abs_diff(item[Stages - 1].red,
                     8'(GrayBase) + 8'(GrayStep) * (palette_index - 8'(GrayFirstIndex))))
      + 10'(abs_diff(item[Stages - 1].green,
                     8'(GrayBase) + 8'(GrayStep) * (palette_index - 8'(GrayFirstIndex))))
      + 10'(abs_diff(item[Stages - 1].blue,
                     8'(GrayBase) + 8'(GrayStep) * (palette_index - 8'(GrayFirstIndex))))))
    else $error("gray match distance mismatch");

  // An occupied head cell blocked by its successor keeps its item
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (valid[0] && !move[1]) |=> (valid[0] && $stable(item[0])))
    else $error("head cell lost an item under stall");

  // An item taken at the input sits in the head cell next cycle
  a_head_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> valid[0])
    else $error("accepted item missing from head cell");

endmodule
